[rtl/core/irpld_pkg.sv]
// ----------------------------------------------------------------------------
// irpld_pkg
// Shared types and constants of the infrared pulse-pattern link detector.
// ----------------------------------------------------------------------------
package irpld_pkg;

	localparam int BOUND_WIDTH     = 16;
	localparam int THR_WIDTH       = 12;
	localparam int CFG_DATA_WIDTH  = 16;
	localparam int CFG_INDEX_WIDTH = 3;
	localparam int MODE_WIDTH      = 4;
	localparam int NUM_SENSORS     = 6;

	localparam logic [CFG_INDEX_WIDTH-1:0] REG_SHORT_MIN = 3'd0;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_SHORT_MAX = 3'd1;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_LONG_MIN  = 3'd2;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_LONG_MAX  = 3'd3;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_THRESHOLD = 3'd4;

	localparam logic [BOUND_WIDTH-1:0] SHORT_MIN_RESET = 16'd95;
	localparam logic [BOUND_WIDTH-1:0] SHORT_MAX_RESET = 16'd105;
	localparam logic [BOUND_WIDTH-1:0] LONG_MIN_RESET  = 16'd195;
	localparam logic [BOUND_WIDTH-1:0] LONG_MAX_RESET  = 16'd205;
	localparam logic [THR_WIDTH-1:0]   THRESHOLD_RESET = 12'd683;

	localparam logic [MODE_WIDTH-1:0] MODE_WAIT   = 4'd0;
	localparam logic [MODE_WIDTH-1:0] MODE_P1     = 4'd1;
	localparam logic [MODE_WIDTH-1:0] MODE_P2     = 4'd2;
	localparam logic [MODE_WIDTH-1:0] MODE_P3     = 4'd3;
	localparam logic [MODE_WIDTH-1:0] MODE_P4     = 4'd4;
	localparam logic [MODE_WIDTH-1:0] MODE_ASK    = 4'd5;
	localparam logic [MODE_WIDTH-1:0] MODE_ACTIVE = 4'd6;
	localparam logic [MODE_WIDTH-1:0] MODE_LOST   = 4'd7;
	localparam logic [MODE_WIDTH-1:0] MODE_D1     = 4'd8;
	localparam logic [MODE_WIDTH-1:0] MODE_D2     = 4'd9;
	localparam logic [MODE_WIDTH-1:0] MODE_D3     = 4'd10;
	localparam logic [MODE_WIDTH-1:0] MODE_D4     = 4'd11;

	typedef struct packed {
		logic [BOUND_WIDTH-1:0] short_min;
		logic [BOUND_WIDTH-1:0] short_max;
		logic [BOUND_WIDTH-1:0] long_min;
		logic [BOUND_WIDTH-1:0] long_max;
		logic [THR_WIDTH-1:0]   threshold;
	} cfg_t;

	typedef struct packed {
		logic rise;
		logic fall;
		logic confirm;
		logic reject;
	} pulse_t;

	typedef struct packed {
		logic [MODE_WIDTH-1:0] mode;
		logic                  link;
		logic                  request;
	} result_t;

endpackage

[rtl/core/irpld_cfg.sv]
// ----------------------------------------------------------------------------
// irpld_cfg
// Timing window bounds and sensor threshold registers.
// ----------------------------------------------------------------------------
module irpld_cfg #(
	parameter int SENSOR_WIDTH = 12
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [irpld_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
	input  logic [irpld_pkg::CFG_DATA_WIDTH-1:0]  cfg_wdata,
	output irpld_pkg::cfg_t                       cfg
);

	localparam logic [irpld_pkg::THR_WIDTH-1:0] THR_MASK =
		(SENSOR_WIDTH >= irpld_pkg::THR_WIDTH) ? {irpld_pkg::THR_WIDTH{1'b1}} :
		irpld_pkg::THR_WIDTH'((1 << SENSOR_WIDTH) - 1);

	irpld_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.short_min <= irpld_pkg::SHORT_MIN_RESET;
			cfg_q.short_max <= irpld_pkg::SHORT_MAX_RESET;
			cfg_q.long_min  <= irpld_pkg::LONG_MIN_RESET;
			cfg_q.long_max  <= irpld_pkg::LONG_MAX_RESET;
			cfg_q.threshold <= irpld_pkg::THRESHOLD_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				irpld_pkg::REG_SHORT_MIN: cfg_q.short_min <= cfg_wdata;
				irpld_pkg::REG_SHORT_MAX: cfg_q.short_max <= cfg_wdata;
				irpld_pkg::REG_LONG_MIN:  cfg_q.long_min  <= cfg_wdata;
				irpld_pkg::REG_LONG_MAX:  cfg_q.long_max  <= cfg_wdata;
				irpld_pkg::REG_THRESHOLD: cfg_q.threshold <=
					cfg_wdata[irpld_pkg::THR_WIDTH-1:0] & THR_MASK;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

[rtl/core/irpld_fsm.sv]
// ----------------------------------------------------------------------------
// irpld_fsm
// Pending flags, tick counter and link mode; one update per advanced item.
// ----------------------------------------------------------------------------
module irpld_fsm #(
	parameter int TICK_COUNT_WIDTH = 16,
	parameter int SENSOR_WIDTH     = 12
) (
	input  logic                                                 clk,
	input  logic                                                 arst_n,
	input  logic                                                 advance,
	input  irpld_pkg::pulse_t                                    pulses,
	input  logic [irpld_pkg::NUM_SENSORS-1:0][SENSOR_WIDTH-1:0]  sensors,
	input  irpld_pkg::cfg_t                                      cfg,
	output irpld_pkg::result_t                                   res
);

	localparam int CW  = (TICK_COUNT_WIDTH > irpld_pkg::BOUND_WIDTH) ?
		TICK_COUNT_WIDTH : irpld_pkg::BOUND_WIDTH;
	localparam int SCW = (SENSOR_WIDTH > irpld_pkg::THR_WIDTH) ?
		SENSOR_WIDTH : irpld_pkg::THR_WIDTH;

	logic [irpld_pkg::MODE_WIDTH-1:0] mode_q, mode_n;
	logic [TICK_COUNT_WIDTH-1:0]      ticks_q, ticks_n, ticks_inc;
	logic                             rise_q, fall_q, confirm_q, reject_q;
	logic                             rise_n, fall_n, confirm_n, reject_n;
	logic                             link_q, link_n, request_q, request_n;
	logic [CW-1:0]                    t_w, lo, hi;
	logic                             short_win, want_rise, below, seen, adv, tmo;
	logic                             all_low, any_high;

	always_comb begin
		all_low  = 1'b1;
		any_high = 1'b0;
		for (int i = 0; i < irpld_pkg::NUM_SENSORS; i++) begin
			if (SCW'(sensors[i]) >= SCW'(cfg.threshold)) all_low = 1'b0;
			if (SCW'(sensors[i]) > SCW'(cfg.threshold)) any_high = 1'b1;
		end
	end

	always_comb begin
		rise_n    = rise_q | pulses.rise;
		fall_n    = fall_q | pulses.fall;
		confirm_n = confirm_q | pulses.confirm;
		reject_n  = reject_q | pulses.reject;
		ticks_inc = (&ticks_q) ? ticks_q : ticks_q + TICK_COUNT_WIDTH'(1);
		ticks_n   = ticks_inc;
		mode_n    = mode_q;
		link_n    = link_q;
		request_n = request_q;

		short_win = mode_q inside {irpld_pkg::MODE_P1, irpld_pkg::MODE_P4,
			irpld_pkg::MODE_D1, irpld_pkg::MODE_D4};
		want_rise = mode_q inside {irpld_pkg::MODE_P2, irpld_pkg::MODE_P4,
			irpld_pkg::MODE_D1, irpld_pkg::MODE_D3};
		t_w   = CW'(ticks_inc);
		lo    = short_win ? CW'(cfg.short_min) : CW'(cfg.long_min);
		hi    = short_win ? CW'(cfg.short_max) : CW'(cfg.long_max);
		below = t_w < lo;
		seen  = want_rise ? rise_n : fall_n;
		adv   = !below && seen && (t_w > lo) && (t_w < hi);
		tmo   = !below && !adv && (t_w > hi);

		case (mode_q)
			irpld_pkg::MODE_P1, irpld_pkg::MODE_P2, irpld_pkg::MODE_P3,
			irpld_pkg::MODE_P4, irpld_pkg::MODE_D1, irpld_pkg::MODE_D2,
			irpld_pkg::MODE_D3, irpld_pkg::MODE_D4: begin
				if (below) begin
					rise_n = 1'b0;
					fall_n = 1'b0;
				end else if (want_rise) begin
					rise_n = 1'b0;
				end else begin
					fall_n = 1'b0;
				end
				if (adv) begin
					if (mode_q == irpld_pkg::MODE_P4) begin
						mode_n    = irpld_pkg::MODE_ASK;
						request_n = 1'b1;
					end else if (mode_q == irpld_pkg::MODE_D4) begin
						mode_n = irpld_pkg::MODE_WAIT;
						link_n = 1'b0;
					end else begin
						mode_n  = mode_q + irpld_pkg::MODE_WIDTH'(1);
						ticks_n = '0;
					end
				end else if (tmo) begin
					request_n = 1'b0;
					if (mode_q inside {irpld_pkg::MODE_P1, irpld_pkg::MODE_P2,
						irpld_pkg::MODE_P3, irpld_pkg::MODE_P4}) begin
						mode_n = irpld_pkg::MODE_WAIT;
					end else begin
						mode_n = irpld_pkg::MODE_ACTIVE;
						link_n = 1'b1;
					end
				end
			end
			irpld_pkg::MODE_ASK: begin
				confirm_n = 1'b0;
				if (confirm_q | pulses.confirm) begin
					request_n = 1'b0;
					mode_n    = irpld_pkg::MODE_ACTIVE;
					link_n    = 1'b1;
				end else begin
					reject_n = 1'b0;
					if (reject_q | pulses.reject) begin
						request_n = 1'b0;
						mode_n    = irpld_pkg::MODE_WAIT;
					end
				end
			end
			irpld_pkg::MODE_ACTIVE: begin
				fall_n = 1'b0;
				if (fall_q | pulses.fall) begin
					mode_n  = irpld_pkg::MODE_D1;
					ticks_n = '0;
				end else if (all_low) begin
					mode_n = irpld_pkg::MODE_LOST;
				end
			end
			irpld_pkg::MODE_LOST: begin
				if (any_high) begin
					request_n = 1'b0;
					mode_n    = irpld_pkg::MODE_ACTIVE;
					link_n    = 1'b1;
				end
			end
			default: begin
				rise_n = 1'b0;
				if (rise_q | pulses.rise) begin
					mode_n  = irpld_pkg::MODE_P1;
					ticks_n = '0;
				end else begin
					mode_n = irpld_pkg::MODE_WAIT;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= irpld_pkg::MODE_WAIT;
			ticks_q   <= '0;
			rise_q    <= 1'b0;
			fall_q    <= 1'b0;
			confirm_q <= 1'b0;
			reject_q  <= 1'b0;
			link_q    <= 1'b0;
			request_q <= 1'b0;
		end else if (advance) begin
			mode_q    <= mode_n;
			ticks_q   <= ticks_n;
			rise_q    <= rise_n;
			fall_q    <= fall_n;
			confirm_q <= confirm_n;
			reject_q  <= reject_n;
			link_q    <= link_n;
			request_q <= request_n;
		end
	end

	assign res.mode    = mode_n;
	assign res.link    = link_n;
	assign res.request = request_n;

	a_link_request_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(link_q && request_q))
		else $error("link and request flags both set");

	a_request_in_ask: assert property (@(posedge clk) disable iff (!arst_n)
		request_q == (mode_q == irpld_pkg::MODE_ASK))
		else $error("request flag out of step with asking mode");

	a_link_modes: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q == irpld_pkg::MODE_ACTIVE || mode_q == irpld_pkg::MODE_LOST ||
		 mode_q == irpld_pkg::MODE_D1 || mode_q == irpld_pkg::MODE_D2 ||
		 mode_q == irpld_pkg::MODE_D3 || mode_q == irpld_pkg::MODE_D4) |-> link_q)
		else $error("link flag clear in a linked mode");

endmodule

[rtl/core/irpld_outbuf.sv]
// ----------------------------------------------------------------------------
// irpld_outbuf
// Two-entry result buffer: output register plus skid register.
// ----------------------------------------------------------------------------
module irpld_outbuf (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  irpld_pkg::result_t d,
	output logic               room,
	output logic               out_valid,
	input  logic               out_stall,
	output irpld_pkg::result_t q
);

	logic               main_valid_q, skid_valid_q;
	irpld_pkg::result_t main_q, skid_q;
	logic               pop;

	assign pop  = main_valid_q && !out_stall;
	assign room = !skid_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (pop) begin
			if (skid_valid_q) begin
				skid_valid_q <= 1'b0;
			end else if (!push) begin
				main_valid_q <= 1'b0;
			end
		end else if (push) begin
			if (main_valid_q) begin
				skid_valid_q <= 1'b1;
			end else begin
				main_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			if (skid_valid_q) begin
				main_q <= skid_q;
			end else if (push) begin
				main_q <= d;
			end
		end else if (push) begin
			if (main_valid_q) begin
				skid_q <= d;
			end else begin
				main_q <= d;
			end
		end
	end

	assign out_valid = main_valid_q;
	assign q         = main_q;

	a_skid_behind_main: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> main_valid_q)
		else $error("skid entry held without an output entry");

endmodule

[rtl/core/ir_pulse_pattern_link_detector.sv]
// ----------------------------------------------------------------------------
// ir_pulse_pattern_link_detector
// Infrared pulse-pattern link detector, one tick item per accepted input.
// ----------------------------------------------------------------------------
// Takes one tick item per clock cycle unless the input stalls, and returns
// one result per item: the item lands in an input register, and the state
// update (pending flags, saturating tick counter, link mode) is done from
// there into a two-entry output buffer. The input stalls only when
// both buffer entries hold results that the sink has not taken. Configuration
// writes take effect at once and are meant for times when no item is in flight.
module ir_pulse_pattern_link_detector #(
	parameter int TICK_COUNT_WIDTH = 16,
	parameter int SENSOR_WIDTH     = 12
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [irpld_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
	input  logic [irpld_pkg::CFG_DATA_WIDTH-1:0]  cfg_wdata,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic                                  rising_edge,
	input  logic                                  falling_edge,
	input  logic                                  confirm_press,
	input  logic                                  reject_press,
	input  logic [SENSOR_WIDTH-1:0]               sensor_a,
	input  logic [SENSOR_WIDTH-1:0]               sensor_b,
	input  logic [SENSOR_WIDTH-1:0]               sensor_c,
	input  logic [SENSOR_WIDTH-1:0]               sensor_d,
	input  logic [SENSOR_WIDTH-1:0]               sensor_e,
	input  logic [SENSOR_WIDTH-1:0]               sensor_f,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic [irpld_pkg::MODE_WIDTH-1:0]      mode,
	output logic                                  link_active,
	output logic                                  request_pending
);

	irpld_pkg::cfg_t                                     cfg;
	irpld_pkg::result_t                                  res_d, res_q;
	irpld_pkg::pulse_t                                   pulses_s1;
	logic [irpld_pkg::NUM_SENSORS-1:0][SENSOR_WIDTH-1:0] sensors_s1;
	logic                                                valid_s1;
	logic                                                room, advance, accept;

	irpld_cfg #(
		.SENSOR_WIDTH(SENSOR_WIDTH)
	) u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.cfg      (cfg)
	);

	assign advance  = valid_s1 && room;
	assign in_stall = valid_s1 && !room;
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pulses_s1.rise    <= rising_edge;
			pulses_s1.fall    <= falling_edge;
			pulses_s1.confirm <= confirm_press;
			pulses_s1.reject  <= reject_press;
			sensors_s1        <= {sensor_f, sensor_e, sensor_d,
				sensor_c, sensor_b, sensor_a};
		end
	end

	irpld_fsm #(
		.TICK_COUNT_WIDTH(TICK_COUNT_WIDTH),
		.SENSOR_WIDTH    (SENSOR_WIDTH)
	) u_fsm (
		.clk    (clk),
		.arst_n (arst_n),
		.advance(advance),
		.pulses (pulses_s1),
		.sensors(sensors_s1),
		.cfg    (cfg),
		.res    (res_d)
	);

	irpld_outbuf u_outbuf (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (advance),
		.d        (res_d),
		.room     (room),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.q        (res_q)
	);

	assign mode            = res_q.mode;
	assign link_active     = res_q.link;
	assign request_pending = res_q.request;

	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && out_valid))
		else $error("input stalled with nothing held downstream");

endmodule
